// File: design/ldtq_pkg.sv
// ----------------------------------------------------------------------------
// ldtq_pkg
// Shared types and constants of the lazy-delete timer queue.
// ----------------------------------------------------------------------------
package ldtq_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int SLOT_W     = 5;
  localparam int TIME_W     = 64;
  localparam int TMO_W      = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK   = 2'd0;
  localparam op_t OP_CREATE = 2'd1;
  localparam op_t OP_START  = 2'd2;
  localparam op_t OP_STOP   = 2'd3;

  // entry held by one queue cell
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] expiry;
  } cell_cmd_t;

endpackage

// File: design/lazy_delete_timer_queue.sv
// ----------------------------------------------------------------------------
// lazy_delete_timer_queue
// Timer slots with a sorted queue of cells ordered by expiry and slot.
// ----------------------------------------------------------------------------
// Create, start and stop are done while the block stays idle. A tick runs the
// head check and, for each queue head it removes, a shift of the cell row;
// each fired slot appears for one cycle with strobe high and must be taken
// then, since the receiver cannot stall the block.
module lazy_delete_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [4:0]  timer_slot,
  input  logic [31:0] timeout_ms,
  input  logic [63:0] now_ms,
  output logic        strobe,
  output logic [4:0]  fired_timer,
  output logic [63:0] fired_expiry,
  output logic        last_fired
);

  localparam int N = ldtq_pkg::NUM_TIMERS;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_POP   = 3'b100
  } state_t;

  state_t state;
  logic [ldtq_pkg::TIME_W-1:0] current_time;
  logic [ldtq_pkg::TIME_W-1:0] slot_expiry [N];
  logic [N-1:0] slot_active;
  logic [N-1:0] slot_deleted;
  logic fired_pending;
  logic [ldtq_pkg::SLOT_W-1:0] pend_slot;
  logic [ldtq_pkg::TIME_W-1:0] pend_expiry;

  ldtq_pkg::cell_cmd_t cmd;
  ldtq_pkg::entry_t    entries [N+1];
  logic                afters  [N+1];
  ldtq_pkg::entry_t    head;
  logic                accept;
  logic                head_del;
  logic                head_due;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;
  assign head   = entries[1];
  assign head_del = slot_deleted[head.slot];
  assign head_due = current_time >= slot_expiry[head.slot];

  always_comb begin
    cmd.insert = accept && operation == ldtq_pkg::OP_START
                 && !slot_active[timer_slot];
    cmd.pop    = state == S_POP;
    cmd.slot   = timer_slot;
    cmd.expiry = slot_expiry[timer_slot];
  end

  assign entries[0] = '0;
  assign afters[0]  = 1'b0;

  for (genvar i = 1; i <= N; i++) begin : g_cell
    ldtq_pkg::entry_t nxt;
    if (i == N) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = entries[i+1];
    end
    ldtq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_entry (entries[i-1]),
      .prev_after (afters[i-1]),
      .next_entry (nxt),
      .entry      (entries[i]),
      .after      (afters[i])
    );
  end

  always_ff @(posedge clk) begin
    strobe     <= 1'b0;
    last_fired <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      current_time  <= '0;
      slot_active   <= '0;
      slot_deleted  <= '0;
      fired_pending <= 1'b0;
      for (int k = 0; k < N; k++) begin
        slot_expiry[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (operation)
              ldtq_pkg::OP_TICK: begin
                current_time  <= now_ms;
                fired_pending <= 1'b0;
                state         <= S_CHECK;
              end
              ldtq_pkg::OP_CREATE: begin
                if (!slot_active[timer_slot]) begin
                  slot_expiry[timer_slot] <= current_time + 64'(timeout_ms);
                end
              end
              ldtq_pkg::OP_START: begin
                if (!slot_active[timer_slot]) begin
                  slot_active[timer_slot]  <= 1'b1;
                  slot_deleted[timer_slot] <= 1'b0;
                end
              end
              default: begin
                slot_deleted[timer_slot] <= 1'b1;
              end
            endcase
          end
        end
        S_CHECK: begin
          priority if (head.valid && (head_del || head_due)) begin
            slot_active[head.slot] <= 1'b0;
            if (head_del) begin
              slot_deleted[head.slot] <= 1'b0;
            end else begin
              if (fired_pending) begin
                strobe       <= 1'b1;
                fired_timer  <= pend_slot;
                fired_expiry <= pend_expiry;
              end
              fired_pending <= 1'b1;
              pend_slot     <= head.slot;
              pend_expiry   <= slot_expiry[head.slot];
            end
            state <= S_POP;
          end else begin
            if (fired_pending) begin
              strobe       <= 1'b1;
              last_fired   <= 1'b1;
              fired_timer  <= pend_slot;
              fired_expiry <= pend_expiry;
            end
            fired_pending <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_CHECK;
        end
      endcase
    end
  end

endmodule

// File: design/ldtq_cell.sv
// ----------------------------------------------------------------------------
// ldtq_cell
// One cell of the sorted queue: holds one entry, shifts on pop and insert.
// ----------------------------------------------------------------------------
module ldtq_cell (
  input  logic                clk,
  input  logic                rst,
  input  ldtq_pkg::cell_cmd_t cmd,
  input  ldtq_pkg::entry_t    prev_entry,
  input  logic                prev_after,
  input  ldtq_pkg::entry_t    next_entry,
  output ldtq_pkg::entry_t    entry,
  output logic                after
);

  logic before_me;

  always_comb begin
    if (entry.expiry != cmd.expiry) begin
      before_me = cmd.expiry < entry.expiry;
    end else begin
      before_me = cmd.slot < entry.slot;
    end
    after = !entry.valid || before_me;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (cmd.pop) begin
      entry <= next_entry;
    end else if (cmd.insert && after) begin
      if (prev_after) begin
        entry <= prev_entry;
      end else begin
        entry.valid  <= 1'b1;
        entry.slot   <= cmd.slot;
        entry.expiry <= cmd.expiry;
      end
    end
  end

endmodule
